[hdl/i2c_master_transfer_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer assertion macros
// Concurrent assertion wrappers clocked on i_clk; they expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while the block is out of reset.
`define I2CMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define I2CMS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define I2CMS_ASSERT(label, prop, msg)
`define I2CMS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hdl/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Shared constants, codes and structures of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cms_pkg;

    // Width of the message length and byte counter.
    localparam int LEN_BITS = 16;

    // Controller status codes.
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
    localparam logic [7:0] ST_TX_ACK     = 8'h28;
    localparam logic [7:0] ST_TX_NAK     = 8'h30;
    localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
    localparam logic [7:0] ST_RX_ACK     = 8'h50;
    localparam logic [7:0] ST_RX_NAK     = 8'h58;

    // Control register bits.
    localparam logic [7:0] C_STA    = 8'h20;
    localparam logic [7:0] C_STP    = 8'h10;
    localparam logic [7:0] C_AAK    = 8'h04;
    localparam logic [7:0] C_IEN    = 8'h80;
    localparam logic [7:0] CTL_MASK = 8'h77;

    // Configuration register indexes.
    localparam logic CFG_RETRY_LIMIT = 1'b0;
    localparam logic CFG_INTR_MODE   = 1'b1;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_EVENT   = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        RES_NONE    = 2'd0,
        RES_OK      = 2'd1,
        RES_FAIL    = 2'd2,
        RES_TIMEOUT = 2'd3
    } t_res;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_ADDR   = 3'd2,
        PH_DATA   = 3'd3,
        PH_RXLAST = 3'd4
    } t_phase;

    typedef struct packed {
        logic reverse_rw;
        logic ignore_nak;
        logic no_start;
        logic read_dir;
    } t_flags;

    // Message context kept between beats.
    typedef struct packed {
        t_phase                phase;
        logic [7:0]            retries;
        logic [LEN_BITS-1:0]   byte_count;
        logic                  busy;
        t_flags                flags;
        logic [LEN_BITS-1:0]   length;
        logic [6:0]            address;
    } t_ctx;

    typedef struct packed {
        t_op        op;
        logic [7:0] status_code;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
        logic [6:0] target_address;
        logic       read_dir;
        logic       no_start;
        logic       ignore_nak;
        logic       reverse_rw;
        logic [15:0] length;
    } t_item;

    typedef struct packed {
        logic                control_valid;
        logic [7:0]          control_byte;
        logic                data_valid;
        logic [7:0]          data_byte;
        logic                received_valid;
        logic [7:0]          received_byte;
        logic [LEN_BITS-1:0] received_index;
        logic [LEN_BITS-1:0] next_index;
        logic                done_res;
        t_res                result_code;
    } t_result;

endpackage

[hdl/i2cms_step.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer decision logic
// Computes the next message context and the result of one beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cms_step
    import i2cms_pkg::*;
(
    input  t_ctx       i_ctx,
    input  t_item      i_item,
    input  logic [7:0] i_retry_limit,
    input  logic       i_intr_mode,
    output t_ctx       o_ctx,
    output t_result    o_res
);

    t_ctx                ld;
    t_ctx                ac;
    t_phase              as_phase;
    logic [7:0]          as_cntr;
    logic                as_dv;
    logic [LEN_BITS-1:0] as_bc;
    logic                as_fin;

    t_ctx                n;
    t_result             r;
    logic [7:0]          cntr;
    logic                fin;
    t_res                fin_code;
    logic                ctl_wait;
    logic                rd;
    logic [7:0]          want;
    logic [LEN_BITS-1:0] bc_inc;

    // Context a start beat loads.
    always_comb begin
        ld             = i_ctx;
        ld.address     = i_item.target_address;
        ld.flags       = '{reverse_rw: i_item.reverse_rw, ignore_nak: i_item.ignore_nak,
                           no_start: i_item.no_start, read_dir: i_item.read_dir};
        ld.length      = i_item.length[LEN_BITS-1:0];
        ld.retries     = i_retry_limit;
        ld.byte_count  = '0;
        ld.busy        = 1'b1;
        ac             = (i_item.op == OP_START) ? ld : i_ctx;
    end

    // Outcome of an acknowledged address phase.
    always_comb begin
        as_cntr  = '0;
        as_dv    = 1'b0;
        as_bc    = '0;
        as_fin   = 1'b0;
        as_phase = PH_DATA;
        if (ac.flags.read_dir) begin
            if (ac.length > LEN_BITS'(1)) begin
                as_cntr = C_AAK;
            end else if (ac.length == LEN_BITS'(1)) begin
                as_phase = PH_RXLAST;
            end else begin
                as_fin = 1'b1;
            end
        end else begin
            if (ac.length != '0) begin
                as_dv = 1'b1;
                as_bc = LEN_BITS'(1);
            end else begin
                as_fin = 1'b1;
            end
        end
    end

    always_comb begin
        n        = i_ctx;
        r        = '0;
        cntr     = '0;
        fin      = 1'b0;
        fin_code = RES_NONE;
        ctl_wait = 1'b0;
        rd       = i_ctx.flags.read_dir;
        want     = rd ? ST_ADDR_R_ACK : ST_ADDR_W_ACK;
        bc_inc   = i_ctx.byte_count + 1'b1;

        unique case (i_item.op)
            OP_START: begin
                n        = ld;
                ctl_wait = 1'b1;
                if (i_item.no_start) begin
                    n.phase      = as_phase;
                    n.byte_count = as_bc;
                    cntr         = as_cntr;
                    r.data_valid = as_dv;
                    r.data_byte  = as_dv ? i_item.tx_byte : 8'h00;
                    fin          = as_fin;
                    fin_code     = RES_OK;
                end else begin
                    cntr    = C_STP | C_STA;
                    n.phase = PH_START;
                end
            end
            OP_EVENT: begin
                if (i_ctx.busy) begin
                    ctl_wait = 1'b1;
                    unique case (i_ctx.phase)
                        PH_START: begin
                            if (i_item.status_code == ST_START ||
                                i_item.status_code == ST_RESTART) begin
                                n.phase      = PH_ADDR;
                                r.data_valid = 1'b1;
                                r.data_byte  = {i_ctx.address,
                                                rd ^ i_ctx.flags.reverse_rw};
                            end else if (i_ctx.retries == '0) begin
                                fin      = 1'b1;
                                fin_code = RES_FAIL;
                            end else begin
                                n.retries = i_ctx.retries - 1'b1;
                                cntr      = C_STP | C_STA;
                                n.phase   = PH_START;
                            end
                        end
                        PH_ADDR: begin
                            if (i_ctx.flags.no_start || i_item.status_code == want) begin
                                n.phase      = as_phase;
                                n.byte_count = as_bc;
                                cntr         = as_cntr;
                                r.data_valid = as_dv;
                                r.data_byte  = as_dv ? i_item.tx_byte : 8'h00;
                                fin          = as_fin;
                                fin_code     = RES_OK;
                            end else if (i_ctx.retries == '0) begin
                                fin      = 1'b1;
                                fin_code = RES_FAIL;
                            end else begin
                                n.retries = i_ctx.retries - 1'b1;
                                cntr      = C_STP | C_STA;
                                n.phase   = PH_START;
                            end
                        end
                        PH_DATA: begin
                            if (rd) begin
                                if (i_item.status_code == ST_RX_ACK) begin
                                    r.received_valid = 1'b1;
                                    r.received_byte  = i_item.rx_byte;
                                    r.received_index = i_ctx.byte_count;
                                    n.byte_count     = bc_inc;
                                    if ({1'b0, i_ctx.length} > ({1'b0, bc_inc} + 1'b1)) begin
                                        cntr = C_AAK;
                                    end else begin
                                        n.phase = PH_RXLAST;
                                    end
                                end else begin
                                    fin      = 1'b1;
                                    fin_code = RES_FAIL;
                                end
                            end else if (i_item.status_code == ST_TX_ACK ||
                                         (i_item.status_code == ST_TX_NAK &&
                                          i_ctx.flags.ignore_nak)) begin
                                if (i_ctx.length > i_ctx.byte_count) begin
                                    r.data_valid = 1'b1;
                                    r.data_byte  = i_item.tx_byte;
                                    n.byte_count = bc_inc;
                                end else begin
                                    fin      = 1'b1;
                                    fin_code = RES_OK;
                                end
                            end else begin
                                fin      = 1'b1;
                                fin_code = RES_FAIL;
                            end
                        end
                        PH_RXLAST: begin
                            fin = 1'b1;
                            if (i_item.status_code == ST_RX_NAK) begin
                                r.received_valid = 1'b1;
                                r.received_byte  = i_item.rx_byte;
                                r.received_index = i_ctx.byte_count;
                                n.byte_count     = bc_inc;
                                fin_code         = RES_OK;
                            end else begin
                                fin_code = RES_FAIL;
                            end
                        end
                        default: begin
                            fin      = 1'b1;
                            fin_code = RES_FAIL;
                        end
                    endcase
                end
            end
            OP_TIMEOUT: begin
                if (i_ctx.busy) begin
                    fin      = 1'b1;
                    fin_code = RES_TIMEOUT;
                end
            end
            default: begin
            end
        endcase

        // A finished message writes STOP alone; otherwise a live message
        // re-arms the controller and waits for the next event.
        if (fin) begin
            n.busy          = 1'b0;
            n.phase         = PH_IDLE;
            r.control_valid = 1'b1;
            r.control_byte  = C_STP;
            r.done_res      = 1'b1;
            r.result_code   = fin_code;
        end else if (ctl_wait) begin
            r.control_valid = 1'b1;
            r.control_byte  = (cntr & CTL_MASK) | (i_intr_mode ? C_IEN : 8'h00);
        end
        r.next_index = n.byte_count;
    end

    assign o_ctx = n;
    assign o_res = r;

endmodule

[hdl/i2c_master_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Drives one I2C message over a status-code controller, one decision a beat.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  s_axis    in         one command or controller event beat
//  m_axis    out        one control/data/receive decision beat per input beat
//  i_cfg_*   in         retry limit and interrupt mode register writes
//
// Each beat passes through the input register and then the result register.
// A new beat is accepted in every cycle while the result register is not stalled.
// The message context register feeds the decision logic straight back, so
// consecutive events see each other's effect with no gap.
// Reset (synchronous, i_rst_n low) empties both registers, idles the message
// and sets retry limit 0 and interrupt mode on.
// A stalled result register holds the input register, which then drops
// s_axis_tready; nothing is lost or repeated.
//
`timescale 1ns / 1ps
`include "i2c_master_transfer_sequencer_defines.svh"

module i2c_master_transfer_sequencer
    import i2cms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input beats.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] status_code, [15:8] rx_byte, [23:16] tx_byte, [30:24] target_address,
    // [31] read_dir, [32] no_start, [33] ignore_nak, [34] reverse_rw,
    // [50:35] length, [55:51] zero.
    input  logic [55:0] s_axis_tdata,
    // [1:0] operation.
    input  logic [1:0]  s_axis_tuser,
    // Result beats.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] control_byte, [15:8] data_byte, [23:16] received_byte,
    // [39:24] received_index, [55:40] next_index, [57:56] result_code,
    // [63:58] zero.
    output logic [63:0] m_axis_tdata,
    // [0] control_valid, [1] data_valid, [2] received_valid.
    output logic [2:0]  m_axis_tuser,
    // done_res: this beat ends the message.
    output logic        m_axis_tlast,
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    t_result    r_out;
    t_ctx       r_ctx;
    logic [7:0] r_retry_limit;
    logic       r_intr_mode;

    logic       proc;
    logic       in_take;
    logic       n_in_valid;
    logic       n_out_valid;
    t_item      in_item;
    t_ctx       n_ctx;
    t_result    n_res;

    // The input register is consumed when the result register is free or
    // being emptied in this cycle.
    assign proc          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign n_in_valid    = in_take || (r_in_valid && !proc);
    assign n_out_valid   = proc || (r_out_valid && !m_axis_tready);

    // Unpack the beat fields from the bus.
    always_comb begin
        in_item.op             = t_op'(s_axis_tuser);
        in_item.status_code    = s_axis_tdata[7:0];
        in_item.rx_byte        = s_axis_tdata[15:8];
        in_item.tx_byte        = s_axis_tdata[23:16];
        in_item.target_address = s_axis_tdata[30:24];
        in_item.read_dir       = s_axis_tdata[31];
        in_item.no_start       = s_axis_tdata[32];
        in_item.ignore_nak     = s_axis_tdata[33];
        in_item.reverse_rw     = s_axis_tdata[34];
        in_item.length         = s_axis_tdata[50:35];
    end

    i2cms_step u_step (
        .i_ctx         (r_ctx),
        .i_item        (r_in),
        .i_retry_limit (r_retry_limit),
        .i_intr_mode   (r_intr_mode),
        .o_ctx         (n_ctx),
        .o_res         (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ctx         <= '{phase: PH_IDLE, default: '0};
            r_retry_limit <= '0;
            r_intr_mode   <= 1'b1;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (proc) begin
                r_ctx <= n_ctx;
            end
            // Registers must be written only while no message beat is in flight; the block does not check it.
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data;
                    CFG_INTR_MODE:   r_intr_mode   <= i_cfg_data[0];
                endcase
            end
        end
        if (in_take) begin
            r_in <= in_item;
        end
        if (proc) begin
            r_out <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.done_res;
    assign m_axis_tuser  = {r_out.received_valid, r_out.data_valid, r_out.control_valid};
    assign m_axis_tdata  = {6'b000000, r_out.result_code, 16'(r_out.next_index),
                            16'(r_out.received_index), r_out.received_byte,
                            r_out.data_byte, r_out.control_byte};

    // The busy flag and the phase must always tell the same story.
    `I2CMS_ASSERT(a_busy_matches_phase, r_ctx.busy == (r_ctx.phase != PH_IDLE), "busy flag disagrees with phase")
    // Every completed message closes with a plain STOP write.
    `I2CMS_ASSERT(a_done_writes_stop, r_out_valid && r_out.done_res |-> r_out.control_valid && r_out.control_byte == C_STP, "message ended without STOP")
    // A received byte always advances the byte counter past its own index.
    `I2CMS_ASSERT(a_rx_advances_count, r_out_valid && r_out.received_valid |-> r_out.next_index == LEN_BITS'(r_out.received_index + 1'b1), "received byte did not advance count")
    // A consumed input beat always lands in the result register.
    `I2CMS_ASSERT(a_proc_fills_output, proc |=> r_out_valid, "processed beat produced no result")
    // Reset leaves both registers empty.
    `I2CMS_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !r_in_valid && !r_out_valid, "registers not empty after reset")

endmodule

[dv/i2c_master_transfer_sequencer_checker.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer checker
// Watches both streams and the register port, predicts every result beat
// from a private copy of the message context and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_checker
    import i2cms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    t_ctx       ctx;
    logic [7:0] retry_limit_q;
    logic       intr_mode_q;
    t_result    decision;
    logic [7:0] wait_ctl;
    t_result    expected_q[$];

    function automatic void close_message(input t_res code);
        ctx.busy             = 1'b0;
        ctx.phase            = PH_IDLE;
        decision.control_valid = 1'b1;
        decision.control_byte  = C_STP;
        decision.done_res      = 1'b1;
        decision.result_code   = code;
    endfunction

    function automatic void retry_or_give_up();
        if (ctx.retries == 8'd0) begin
            close_message(RES_FAIL);
        end else begin
            ctx.retries = ctx.retries - 8'd1;
            wait_ctl    = C_STP | C_STA;
            ctx.phase   = PH_START;
        end
    endfunction

    // Outcome of the address byte; a no-start message fakes the right ACK.
    function automatic void address_outcome(input logic [7:0] status, input logic faked,
                                            input logic [7:0] tx);
        logic [7:0] want;
        want = ctx.flags.read_dir ? ST_ADDR_R_ACK : ST_ADDR_W_ACK;
        if (faked)
            status = want;
        if (status != want) begin
            retry_or_give_up();
            return;
        end
        ctx.byte_count = '0;
        if (ctx.flags.read_dir) begin
            if (ctx.length > 1) begin
                ctx.phase = PH_DATA;
                wait_ctl  = C_AAK;
            end else if (ctx.length == 1) begin
                ctx.phase = PH_RXLAST;
            end else begin
                close_message(RES_OK);
            end
        end else begin
            ctx.phase = PH_DATA;
            if (ctx.length != 0) begin
                decision.data_valid = 1'b1;
                decision.data_byte  = tx;
                ctx.byte_count      = LEN_BITS'(1);
            end else begin
                close_message(RES_OK);
            end
        end
    endfunction

    function automatic void controller_event(input logic [7:0] status, input logic [7:0] rx,
                                             input logic [7:0] tx);
        logic [7:0] st;
        case (ctx.phase)
            PH_START: begin
                if (status == ST_START || status == ST_RESTART) begin
                    ctx.phase           = PH_ADDR;
                    decision.data_valid = 1'b1;
                    decision.data_byte  = {ctx.address,
                                           ctx.flags.read_dir ^ ctx.flags.reverse_rw};
                end else begin
                    retry_or_give_up();
                end
            end
            PH_ADDR: begin
                address_outcome(status, ctx.flags.no_start, tx);
            end
            PH_DATA: begin
                if (ctx.flags.read_dir) begin
                    if (status == ST_RX_ACK) begin
                        decision.received_valid = 1'b1;
                        decision.received_byte  = rx;
                        decision.received_index = ctx.byte_count;
                        ctx.byte_count          = ctx.byte_count + 1'b1;
                        if (int'(ctx.length) > int'(ctx.byte_count) + 1)
                            wait_ctl = C_AAK;
                        else
                            ctx.phase = PH_RXLAST;
                    end else begin
                        close_message(RES_FAIL);
                    end
                end else begin
                    st = status;
                    if (st == ST_TX_NAK && ctx.flags.ignore_nak)
                        st = ST_TX_ACK;
                    if (st == ST_TX_ACK) begin
                        if (ctx.length > ctx.byte_count) begin
                            decision.data_valid = 1'b1;
                            decision.data_byte  = tx;
                            ctx.byte_count      = ctx.byte_count + 1'b1;
                        end else begin
                            close_message(RES_OK);
                        end
                    end else begin
                        close_message(RES_FAIL);
                    end
                end
            end
            PH_RXLAST: begin
                if (status == ST_RX_NAK) begin
                    decision.received_valid = 1'b1;
                    decision.received_byte  = rx;
                    decision.received_index = ctx.byte_count;
                    ctx.byte_count          = ctx.byte_count + 1'b1;
                    close_message(RES_OK);
                end else begin
                    close_message(RES_FAIL);
                end
            end
            default: begin
                close_message(RES_FAIL);
            end
        endcase
    endfunction

    function automatic t_result sequence_beat(input t_item it);
        decision = '0;
        wait_ctl = '0;
        case (it.op)
            OP_START: begin
                ctx.address          = it.target_address;
                ctx.flags.read_dir   = it.read_dir;
                ctx.flags.no_start   = it.no_start;
                ctx.flags.ignore_nak = it.ignore_nak;
                ctx.flags.reverse_rw = it.reverse_rw;
                ctx.length           = it.length[LEN_BITS-1:0];
                ctx.retries          = retry_limit_q;
                ctx.byte_count       = '0;
                ctx.busy             = 1'b1;
                if (it.no_start) begin
                    ctx.phase = PH_ADDR;
                    address_outcome(8'h00, 1'b1, it.tx_byte);
                end else begin
                    wait_ctl  = C_STP | C_STA;
                    ctx.phase = PH_START;
                end
            end
            OP_EVENT: begin
                if (ctx.busy)
                    controller_event(it.status_code, it.rx_byte, it.tx_byte);
            end
            OP_TIMEOUT: begin
                if (ctx.busy)
                    close_message(RES_TIMEOUT);
            end
            default: begin
            end
        endcase
        // A message still running waits for the next event.
        if ((it.op == OP_START || it.op == OP_EVENT) && ctx.busy) begin
            decision.control_valid = 1'b1;
            decision.control_byte  = (wait_ctl & CTL_MASK) | (intr_mode_q ? C_IEN : 8'h00);
        end
        decision.next_index = ctx.byte_count;
        return decision;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_item   beat_in;
        t_result want;
        if (!i_rst_n) begin
            ctx           = '0;
            retry_limit_q = 8'd0;
            intr_mode_q   = 1'b1;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RETRY_LIMIT)
                    retry_limit_q = i_cfg_data;
                else
                    intr_mode_q = i_cfg_data[0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                beat_in.op             = t_op'(s_axis_tuser);
                beat_in.status_code    = s_axis_tdata[7:0];
                beat_in.rx_byte        = s_axis_tdata[15:8];
                beat_in.tx_byte        = s_axis_tdata[23:16];
                beat_in.target_address = s_axis_tdata[30:24];
                beat_in.read_dir       = s_axis_tdata[31];
                beat_in.no_start       = s_axis_tdata[32];
                beat_in.ignore_nak     = s_axis_tdata[33];
                beat_in.reverse_rw     = s_axis_tdata[34];
                beat_in.length         = s_axis_tdata[50:35];
                expected_q.push_back(sequence_beat(beat_in));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result beat 0x%0h with no beat pending", $time,
                             m_axis_tdata);
                end else begin
                    want = expected_q.pop_front();
                    check_field("control_valid", 32'(want.control_valid),
                                32'(m_axis_tuser[0]));
                    check_field("control_byte", 32'(want.control_byte),
                                32'(m_axis_tdata[7:0]));
                    check_field("data_valid", 32'(want.data_valid), 32'(m_axis_tuser[1]));
                    check_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[15:8]));
                    check_field("received_valid", 32'(want.received_valid),
                                32'(m_axis_tuser[2]));
                    check_field("received_byte", 32'(want.received_byte),
                                32'(m_axis_tdata[23:16]));
                    check_field("received_index", 32'(want.received_index),
                                32'(m_axis_tdata[39:24]));
                    check_field("next_index", 32'(want.next_index),
                                32'(m_axis_tdata[55:40]));
                    check_field("done_res", 32'(want.done_res), 32'(m_axis_tlast));
                    check_field("result_code", 32'(want.result_code),
                                32'(m_axis_tdata[57:56]));
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

[dv/tb_i2c_master_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer testbench
// Drives directed and random I2C message traffic into the sequencer under
// random source gaps and sink stalls, across several register settings; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_master_transfer_sequencer;
    import i2cms_pkg::*;

    // Operation code the block has no use for; it must be ignored.
    localparam logic [1:0] OP_UNUSED        = 2'd3;
    // Beats per random phase; six phases give roughly 1100 beats in all.
    localparam int         PHASE_BEATS      = 180;
    localparam int         NUM_PHASES       = 6;
    // Length of the one long sink hold-off that backs the block up.
    localparam int         LONG_HOLD_CYCLES = 300;
    // Bound on the whole run for the watchdog below.
    localparam int         CYCLE_LIMIT      = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [7:0] status_code, [15:8] rx_byte, [23:16] tx_byte, [30:24] target_address,
    // [31] read_dir, [32] no_start, [33] ignore_nak, [34] reverse_rw, [50:35] length.
    logic [55:0] s_axis_tdata;
    // [1:0] operation.
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] control_byte, [15:8] data_byte, [23:16] received_byte,
    // [39:24] received_index, [55:40] next_index, [57:56] result_code.
    logic [63:0] m_axis_tdata;
    // [0] control_valid, [1] data_valid, [2] received_valid.
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;

    int          fail_count;
    int          pending;
    int          beats_sent;
    int          cycles;
    // Idling controls: gaps_on for the source, stalls_on for the sink.
    bit          gaps_on;
    bit          stalls_on;
    // The stimulus asks for the long hold-off; the sink runs it once.
    bit          hold_req;
    bit          hold_done;
    bit          long_hold;
    // Retry limit currently programmed, so messages can plan their retries.
    logic [7:0]  retry_now;

    i2c_master_transfer_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    i2c_master_transfer_sequencer_checker CHECKER (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sink side. Ready drops in random bursts while stalls are enabled, and
    // once for a long stretch so the block's registers fill and it pushes
    // back on the source. Each pass assigns ready once, at a falling edge.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done     = 1'b1;
                long_hold     = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Every field random; callers override what matters for the beat.
    function automatic t_item random_beat(input t_op op);
        t_item it;
        it.op             = op;
        it.status_code    = 8'($urandom);
        it.rx_byte        = 8'($urandom);
        it.tx_byte        = 8'($urandom);
        it.target_address = 7'($urandom);
        it.read_dir       = 1'($urandom);
        it.no_start       = 1'($urandom);
        it.ignore_nak     = 1'($urandom);
        it.reverse_rw     = 1'($urandom);
        it.length         = 16'($urandom);
        return it;
    endfunction

    function automatic t_item start_of(input logic [6:0] addr, input logic rd,
                                       input logic nost, input logic ign,
                                       input logic rev, input logic [15:0] len);
        t_item it;
        it                = random_beat(OP_START);
        it.target_address = addr;
        it.read_dir       = rd;
        it.no_start       = nost;
        it.ignore_nak     = ign;
        it.reverse_rw     = rev;
        it.length         = len;
        return it;
    endfunction

    function automatic t_item event_of(input logic [7:0] status);
        t_item it;
        it             = random_beat(OP_EVENT);
        it.status_code = status;
        return it;
    endfunction

    // Offers one beat from a falling edge and returns on the falling edge
    // after it was taken, possibly after an idle gap. Valid stays high from
    // one beat to the next unless a gap lowers it.
    task automatic put_beat(input t_item it);
        s_axis_tdata  <= {5'b0, it.length, it.reverse_rw, it.ignore_nak, it.no_start,
                          it.read_dir, it.target_address, it.tx_byte, it.rx_byte,
                          it.status_code};
        s_axis_tuser  <= it.op;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
        // No gaps during the long hold-off, so the block really backs up.
        if (gaps_on && !long_hold && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits until every predicted result has come back, then lets the clock
    // run on, so register writes land on an idle block.
    task automatic wait_drained();
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // One message as a controller would report it: START and address with
    // a planned number of failed attempts, then the data phase. A few
    // messages break off early with a bad status, a timeout or simply by
    // being abandoned for the next start.
    task automatic run_message();
        logic       rd;
        logic       nost;
        logic       ign;
        logic [7:0] st;
        int         len;
        int         planned;
        int         fails;
        int         k;
        bit         cut;
        rd   = 1'($urandom_range(0, 1));
        nost = ($urandom_range(0, 4) == 0);
        ign  = 1'($urandom_range(0, 1));
        // Mostly short messages; now and then a long or a full-range length.
        k = $urandom_range(0, 19);
        if (k < 14)
            len = $urandom_range(0, 5);
        else if (k < 18)
            len = $urandom_range(6, 40);
        else
            len = $urandom_range(0, 65535);
        put_beat(start_of(7'($urandom_range(0, 127)), rd, nost, ign,
                          1'($urandom_range(0, 1)), 16'(len)));
        if (!nost) begin
            fails = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            for (k = 0; k <= fails; k++) begin
                // Out of retries: the block has already failed the message.
                if (k > retry_now)
                    return;
                if (k < fails && $urandom_range(0, 1) == 0) begin
                    do
                        st = 8'($urandom_range(0, 255));
                    while (st == ST_START || st == ST_RESTART);
                    put_beat(event_of(st));
                end else begin
                    put_beat(event_of($urandom_range(0, 1) ? ST_START : ST_RESTART));
                    if (k < fails) begin
                        // Wrong acknowledge, often the one of the other direction.
                        if ($urandom_range(0, 1)) begin
                            st = rd ? ST_ADDR_W_ACK : ST_ADDR_R_ACK;
                        end else begin
                            do
                                st = 8'($urandom_range(0, 255));
                            while (st == (rd ? ST_ADDR_R_ACK : ST_ADDR_W_ACK));
                        end
                        put_beat(event_of(st));
                    end else begin
                        put_beat(event_of(rd ? ST_ADDR_R_ACK : ST_ADDR_W_ACK));
                    end
                end
            end
        end
        if (len == 0)
            return;
        planned = len;
        cut     = 1'b0;
        if (len > 48 || $urandom_range(0, 24) == 0) begin
            planned = $urandom_range(0, (len > 12) ? 12 : len - 1);
            cut     = 1'b1;
        end
        for (k = 0; k < planned; k++) begin
            if ($urandom_range(0, 49) == 0) begin
                // A bad data-phase status ends the message at once.
                st = (rd || ign) ? 8'($urandom_range(0, 255)) : ST_TX_NAK;
                put_beat(event_of(st));
                return;
            end
            if (rd)
                st = (k == len - 1) ? ST_RX_NAK : ST_RX_ACK;
            else
                st = (ign && $urandom_range(0, 1)) ? ST_TX_NAK : ST_TX_ACK;
            put_beat(event_of(st));
        end
        if (cut && $urandom_range(0, 1))
            put_beat(random_beat(OP_TIMEOUT));
    endtask

    // Short directed sequence on reset settings (no retries, interrupt mode).
    task automatic directed_beats();
        t_item it;
        // Idle block: event, timeout and the unused code do nothing.
        put_beat(random_beat(OP_EVENT));
        put_beat(random_beat(OP_TIMEOUT));
        put_beat(random_beat(t_op'(OP_UNUSED)));
        // One-byte write to the top address with the direction bit inverted.
        put_beat(start_of(7'h7F, 1'b0, 1'b0, 1'b0, 1'b1, 16'd1));
        put_beat(event_of(ST_START));
        it         = event_of(ST_ADDR_W_ACK);
        it.tx_byte = 8'hFF;
        put_beat(it);
        put_beat(event_of(ST_TX_ACK));
        // Two-byte read from address zero after a repeated start.
        put_beat(start_of(7'h00, 1'b1, 1'b0, 1'b0, 1'b0, 16'd2));
        put_beat(event_of(ST_RESTART));
        put_beat(event_of(ST_ADDR_R_ACK));
        it         = event_of(ST_RX_ACK);
        it.rx_byte = 8'hFF;
        put_beat(it);
        it         = event_of(ST_RX_NAK);
        it.rx_byte = 8'h00;
        put_beat(it);
        // No-start messages: empty write, one-byte read, write with NAK ignored.
        put_beat(start_of(7'h55, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        put_beat(start_of(7'h2A, 1'b1, 1'b1, 1'b0, 1'b0, 16'd1));
        put_beat(event_of(ST_RX_NAK));
        put_beat(start_of(7'h11, 1'b0, 1'b1, 1'b1, 1'b0, 16'd2));
        put_beat(event_of(ST_TX_NAK));
        put_beat(event_of(ST_TX_ACK));
        // Failed START with no retries left.
        put_beat(start_of(7'h01, 1'b0, 1'b0, 1'b0, 1'b0, 16'd3));
        put_beat(event_of(ST_TX_ACK));
        // Full-length read aborted by a timeout.
        put_beat(start_of(7'h02, 1'b1, 1'b0, 1'b0, 1'b0, 16'hFFFF));
        put_beat(event_of(ST_START));
        put_beat(random_beat(OP_TIMEOUT));
        // A new start abandons the message in flight.
        put_beat(start_of(7'h03, 1'b1, 1'b0, 1'b0, 1'b1, 16'd3));
        put_beat(start_of(7'h04, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
    endtask

    // Main stimulus: reset, directed beats, then random phases on several
    // register settings, the extremes among them. The last phase runs with
    // no idling on either side.
    initial begin
        logic [7:0] retry_plan [NUM_PHASES];
        logic       intr_plan  [NUM_PHASES];
        int         p;
        int         phase_end;
        bit         tail;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_RETRY_LIMIT;
        i_cfg_data    = '0;
        beats_sent    = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        hold_req      = 1'b0;
        retry_now     = 8'd0;
        retry_plan    = '{8'd255, 8'd1, 8'd0, 8'd0, 8'd2, 8'd255};
        intr_plan     = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        retry_plan[3] = 8'($urandom_range(3, 254));
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_beats();
        s_axis_tvalid <= 1'b0;

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_reg(CFG_RETRY_LIMIT, retry_plan[p]);
            write_reg(CFG_INTR_MODE, {7'b0, intr_plan[p]});
            retry_now = retry_plan[p];
            tail      = (p == NUM_PHASES - 1);
            // Early in the second phase the sink holds off for a long time.
            if (p == 1)
                hold_req = 1'b1;
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                gaps_on   = !tail && ($urandom_range(0, 3) != 0);
                stalls_on = !tail && ($urandom_range(0, 3) != 0);
                // Some noise between messages: stray events, timeouts, bad codes.
                if ($urandom_range(0, 5) == 0) begin
                    case ($urandom_range(0, 2))
                        0: put_beat(random_beat(OP_EVENT));
                        1: put_beat(random_beat(OP_TIMEOUT));
                        default: put_beat(random_beat(t_op'(OP_UNUSED)));
                    endcase
                end
                run_message();
            end
            s_axis_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
